// ===== sv/fmtl_pkg.sv =====
// Shared types and constants for the field map trilinear lookup.
// Used by the front, queue, back and top modules; no dependencies.
`default_nettype none
package fmtl_pkg;

   localparam int ADDR_W  = 15;
   localparam int DEPTH   = 32768;
   localparam int COMP_W  = 24;
   localparam int ENTRY_W = 3 * COMP_W;
   localparam int CELL_W  = 8;
   localparam int WGT_W   = 17;
   localparam int CSR_W   = 4;

   localparam int NX_DEF = 32;
   localparam int NY_DEF = 32;
   localparam int NZ_DEF = 32;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_W-1:0] REG_ORIGIN_X   = 4'd0;
   localparam logic [CSR_W-1:0] REG_ORIGIN_Y   = 4'd1;
   localparam logic [CSR_W-1:0] REG_ORIGIN_Z   = 4'd2;
   localparam logic [CSR_W-1:0] REG_INV_STEP_X = 4'd3;
   localparam logic [CSR_W-1:0] REG_INV_STEP_Y = 4'd4;
   localparam logic [CSR_W-1:0] REG_INV_STEP_Z = 4'd5;
   localparam logic [CSR_W-1:0] REG_FIELD_SCALE = 4'd6;
   localparam logic [CSR_W-1:0] REG_QUADRANT   = 4'd7;

   typedef struct packed {
      logic                      opcode;
      logic [ADDR_W-1:0]         entry_index;
      logic signed [COMP_W-1:0]  entry_bx;
      logic signed [COMP_W-1:0]  entry_by;
      logic signed [COMP_W-1:0]  entry_bz;
      logic signed [31:0]        pos_x;
      logic signed [31:0]        pos_y;
      logic signed [31:0]        pos_z;
   } req_word_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] field_x;
      logic signed [COMP_W-1:0] field_y;
      logic signed [COMP_W-1:0] field_z;
      logic                     inside_res;
   } rsp_word_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic [31:0]        inv_step_x;
      logic [31:0]        inv_step_y;
      logic [31:0]        inv_step_z;
      logic [31:0]        field_scale;
      logic               quadrant_symmetric;
   } cfg_type;

   // one classified job between front and back
   typedef struct packed {
      logic                is_write;
      logic [ADDR_W-1:0]   entry_index;
      logic [ENTRY_W-1:0]  entry;
      logic                in_grid;
      logic                flip_x;
      logic                flip_z;
      logic [CELL_W-1:0]   cell_x;
      logic [CELL_W-1:0]   cell_y;
      logic [CELL_W-1:0]   cell_z;
      logic [WGT_W-1:0]    w_x;
      logic [WGT_W-1:0]    w_y;
      logic [WGT_W-1:0]    w_z;
   } job_type;

endpackage
`default_nettype wire

// ===== sv/fmtl_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module fmtl_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule
`default_nettype wire

// ===== sv/fmtl_queue.sv =====
// Two-entry job queue between front and back.
// Depends on fmtl_pkg.
`default_nettype none
module fmtl_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire fmtl_pkg::job_type push_job,
   input  wire logic             pop,
   output fmtl_pkg::job_type     head,
   output logic                  full,
   output logic                  empty
);

   fmtl_pkg::job_type ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign head  = ent_ff[rd_ptr_ff];
   assign full  = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// ===== sv/fmtl_front.sv =====
// Front end: takes request words, folds the quadrant, maps each axis to cell
// and weight, and pushes a job. Depends on fmtl_pkg.
`default_nettype none
module fmtl_front #(
   parameter int NX = fmtl_pkg::NX_DEF,
   parameter int NY = fmtl_pkg::NY_DEF,
   parameter int NZ = fmtl_pkg::NZ_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fmtl_pkg::cfg_type     cfg,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire fmtl_pkg::req_word_type req_word,
   output logic                       push,
   output fmtl_pkg::job_type          push_job,
   input  wire logic                  q_full
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_CALC = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [2:0] step_ff, step_in;
   fmtl_pkg::job_type job_ff, job_in;
   logic [32:0] dabs_ff [3];
   logic [32:0] dabs_in [3];
   logic [47:0] plo_ff, plo_in;

   logic                accept;
   logic signed [31:0]  pos [3];
   logic signed [31:0]  org [3];
   logic [31:0]         inv [3];
   logic                negp [3];
   logic signed [32:0]  pf;
   logic signed [33:0]  diff;
   logic                bad;
   logic [1:0]          axis;
   logic [32:0]         dsel;
   logic [31:0]         isel;
   logic [32:0]         nm1;
   logic [fmtl_pkg::CELL_W-1:0] nm2;
   logic [48:0]         phi;
   logic [64:0]         prod;
   logic [32:0]         ip;
   logic                top;
   logic                outside;
   logic [fmtl_pkg::CELL_W-1:0] cidx;
   logic [fmtl_pkg::WGT_W-1:0]  wgt;

   assign req_stall = state_ff != F_IDLE;
   assign accept    = req_valid && !req_stall;
   assign push      = (state_ff == F_PUSH) && !q_full;
   assign push_job  = job_ff;

   assign pos[0] = req_word.pos_x;
   assign pos[1] = req_word.pos_y;
   assign pos[2] = req_word.pos_z;
   assign org[0] = cfg.origin_x;
   assign org[1] = cfg.origin_y;
   assign org[2] = cfg.origin_z;
   assign inv[0] = cfg.inv_step_x;
   assign inv[1] = cfg.inv_step_y;
   assign inv[2] = cfg.inv_step_z;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      job_in   = job_ff;
      dabs_in  = dabs_ff;
      plo_in   = plo_ff;
      bad      = 1'b0;
      pf       = '0;
      diff     = '0;
      for (int a = 0; a < 3; a++) begin
         negp[a] = (a < 2) && cfg.quadrant_symmetric && pos[a][31];
      end

      axis = step_ff[2:1];
      case (axis)
         2'd0: begin
            isel = cfg.inv_step_x;
            nm1  = 33'(NX - 1);
            nm2  = fmtl_pkg::CELL_W'(NX - 2);
         end
         2'd1: begin
            isel = cfg.inv_step_y;
            nm1  = 33'(NY - 1);
            nm2  = fmtl_pkg::CELL_W'(NY - 2);
         end
         default: begin
            isel = cfg.inv_step_z;
            nm1  = 33'(NZ - 1);
            nm2  = fmtl_pkg::CELL_W'(NZ - 2);
         end
      endcase
      dsel = dabs_ff[axis];
      phi  = dsel[32:16] * isel;
      prod = {phi, 16'b0} + {17'b0, plo_ff};
      ip   = prod[64:32];
      top  = ip == nm1;
      outside = (ip > nm1) || (top && (prod[31:0] != 32'd0));
      cidx = top ? nm2 : ip[fmtl_pkg::CELL_W-1:0];
      wgt  = top ? fmtl_pkg::WGT_W'(65536) : {1'b0, prod[31:16]};

      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               job_in.is_write    = req_word.opcode == fmtl_pkg::OP_WRITE;
               job_in.entry_index = req_word.entry_index;
               job_in.entry       = {req_word.entry_bx, req_word.entry_by, req_word.entry_bz};
               job_in.flip_x      = negp[0] ^ negp[1];
               job_in.flip_z      = negp[1];
               for (int a = 0; a < 3; a++) begin
                  pf   = negp[a] ? -33'(pos[a]) : 33'(pos[a]);
                  diff = 34'(pf) - 34'(org[a]);
                  dabs_in[a] = diff[32:0];
                  bad  = bad || diff[33] || (inv[a] == 32'd0);
               end
               job_in.in_grid = !bad;
               step_in  = 3'd0;
               state_in = (req_word.opcode == fmtl_pkg::OP_WRITE) ? F_PUSH : F_CALC;
            end
         end
         F_CALC: begin
            if (!step_ff[0]) begin
               plo_in = 48'(dsel[15:0]) * 48'(isel);
            end else begin
               if (outside) begin
                  job_in.in_grid = 1'b0;
               end
               case (axis)
                  2'd0: begin
                     job_in.cell_x = cidx;
                     job_in.w_x    = wgt;
                  end
                  2'd1: begin
                     job_in.cell_y = cidx;
                     job_in.w_y    = wgt;
                  end
                  default: begin
                     job_in.cell_z = cidx;
                     job_in.w_z    = wgt;
                  end
               endcase
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      dabs_ff <= dabs_in;
      plo_ff  <= plo_in;
   end

endmodule
`default_nettype wire

// ===== sv/fmtl_back.sv =====
// Back end: performs grid writes, fetches the eight corners of a query,
// interpolates x, y, z, scales and saturates. Depends on fmtl_pkg.
`default_nettype none
module fmtl_back #(
   parameter int NY = fmtl_pkg::NY_DEF,
   parameter int NZ = fmtl_pkg::NZ_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [31:0]           field_scale,
   input  wire fmtl_pkg::job_type     head,
   input  wire logic                  q_empty,
   output logic                       pop,
   output logic                       ram_we,
   output logic [fmtl_pkg::ADDR_W-1:0] ram_addr,
   output logic [fmtl_pkg::ENTRY_W-1:0] ram_wdata,
   input  wire logic [fmtl_pkg::ENTRY_W-1:0] ram_rdata,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output fmtl_pkg::rsp_word_type     rsp_word
);

   localparam int AW = fmtl_pkg::ADDR_W;
   localparam int CW = fmtl_pkg::COMP_W;

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_READ  = 3'd1;
   localparam logic [2:0] B_MIX   = 3'd2;
   localparam logic [2:0] B_SCALE = 3'd3;
   localparam logic [2:0] B_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   fmtl_pkg::job_type job_ff, job_in;
   logic signed [CW-1:0] v_ff [3][8];
   logic signed [CW-1:0] v_in [3][8];
   logic signed [56:0]   sp_ff [3];
   logic signed [56:0]   sp_in [3];
   logic                 rsp_valid_ff, rsp_valid_in;
   fmtl_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic [2:0]           k;
   logic [AW-1:0]        ax, ay, az, caddr;
   logic [fmtl_pkg::WGT_W-1:0] wsel;
   logic signed [CW:0]   dif  [3];
   logic signed [42:0]   mprod [3];
   logic signed [42:0]   msum [3];
   logic [CW-1:0]        mres [3];
   logic signed [56:0]   sr   [3];
   logic signed [40:0]   q    [3];
   logic signed [40:0]   nq   [3];
   logic                 flip [3];
   logic [CW-1:0]        fo   [3];
   logic                 out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // corner k = dx + 2*dy + 4*dz, address wraps to the store size
   always_comb begin
      k  = cnt_ff[2:0];
      ax = AW'(job_ff.cell_x) + AW'(k[0]);
      ay = AW'(job_ff.cell_y) + AW'(k[1]);
      az = AW'(job_ff.cell_z) + AW'(k[2]);
      caddr = AW'(AW'(ax * AW'(NY)) + ay) * AW'(NZ) + az;
   end

   always_comb begin
      pop       = (state_ff == B_IDLE) && !q_empty;
      ram_we    = pop && head.is_write;
      ram_wdata = head.entry;
      ram_addr  = (state_ff == B_IDLE) ? head.entry_index : caddr;
   end

   // operands are always the two oldest values; the result joins the tail
   always_comb begin
      if (cnt_ff < 4'd4) begin
         wsel = job_ff.w_x;
      end else if (cnt_ff < 4'd6) begin
         wsel = job_ff.w_y;
      end else begin
         wsel = job_ff.w_z;
      end
      flip[0] = job_ff.flip_x;
      flip[1] = 1'b0;
      flip[2] = job_ff.flip_z;
      for (int c = 0; c < 3; c++) begin
         dif[c]   = (CW+1)'(v_ff[c][1]) - (CW+1)'(v_ff[c][0]);
         mprod[c] = dif[c] * $signed({1'b0, wsel});
         msum[c]  = mprod[c] + 43'sd32768;
         mres[c]  = v_ff[c][0] + msum[c][39:16];
         sr[c]    = sp_ff[c] + 57'sd32768;
         q[c]     = sr[c][56:16];
         nq[c]    = flip[c] ? -q[c] : q[c];
         if (nq[c] > 41'sd8388607) begin
            fo[c] = 24'h7FFFFF;
         end else if (nq[c] < -41'sd8388608) begin
            fo[c] = 24'h800000;
         end else begin
            fo[c] = nq[c][CW-1:0];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      job_in       = job_ff;
      v_in         = v_ff;
      sp_in        = sp_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         B_IDLE: begin
            if (pop && !head.is_write) begin
               job_in   = head;
               cnt_in   = 4'd0;
               state_in = head.in_grid ? B_READ : B_DONE;
            end
         end
         B_READ: begin
            if (cnt_ff != 4'd0) begin
               v_in[0][3'(cnt_ff - 4'd1)] = ram_rdata[3*CW-1:2*CW];
               v_in[1][3'(cnt_ff - 4'd1)] = ram_rdata[2*CW-1:CW];
               v_in[2][3'(cnt_ff - 4'd1)] = ram_rdata[CW-1:0];
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd8) begin
               cnt_in   = 4'd0;
               state_in = B_MIX;
            end
         end
         B_MIX: begin
            for (int c = 0; c < 3; c++) begin
               for (int i = 0; i < 6; i++) begin
                  v_in[c][i] = v_ff[c][i+2];
               end
               v_in[c][3'(4'd6 - cnt_ff)] = mres[c];
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd6) begin
               state_in = B_SCALE;
            end
         end
         B_SCALE: begin
            for (int c = 0; c < 3; c++) begin
               sp_in[c] = v_ff[c][0] * $signed({1'b0, field_scale});
            end
            state_in = B_DONE;
         end
         B_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (job_ff.in_grid) begin
                  rsp_word_in.field_x = fo[0];
                  rsp_word_in.field_y = fo[1];
                  rsp_word_in.field_z = fo[2];
                  rsp_word_in.inside_res = 1'b1;
               end else begin
                  rsp_word_in = '0;
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      v_ff        <= v_in;
      sp_ff       <= sp_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule
`default_nettype wire

// ===== sv/field_map_trilinear_lookup_top.sv =====
// Top level of the field map trilinear lookup: control registers, front,
// job queue, back and grid RAM. Depends on fmtl_pkg and all fmtl_* modules.
//
//   port group  direction  handshake            word
//   req_*       in         req_valid/req_stall  fmtl_pkg::req_word_type
//   rsp_*       out        rsp_valid/rsp_stall  fmtl_pkg::rsp_word_type
//   csr_*       in         csr_valid/csr_ready  csr_index, csr_data
//
// A write word goes from the front's idle state to its push state; the back
// writes it as it pops it. A query is mapped in the front (the 33x32 bit
// position product is split into halves per axis); the back then does the
// eight corner reads from the single-port grid RAM, 7 interpolation steps,
// scale and output; it ends one query before it pops the next. Reset is
// synchronous; the grid RAM is not cleared. A stalled result holds the back;
// the front keeps working until the two-entry queue fills, then stalls req.
`default_nettype none
module field_map_trilinear_lookup_top #(
   parameter int NX = fmtl_pkg::NX_DEF,
   parameter int NY = fmtl_pkg::NY_DEF,
   parameter int NZ = fmtl_pkg::NZ_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire fmtl_pkg::req_word_type       req_word,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output fmtl_pkg::rsp_word_type            rsp_word,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [fmtl_pkg::CSR_W-1:0]   csr_index,
   input  wire logic [31:0]                  csr_data
);

   fmtl_pkg::cfg_type cfg_ff, cfg_in;
   fmtl_pkg::job_type push_job, head;
   logic push, pop, q_full, q_empty;
   logic ram_we;
   logic [fmtl_pkg::ADDR_W-1:0]  ram_addr;
   logic [fmtl_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            fmtl_pkg::REG_ORIGIN_X:    cfg_in.origin_x = csr_data;
            fmtl_pkg::REG_ORIGIN_Y:    cfg_in.origin_y = csr_data;
            fmtl_pkg::REG_ORIGIN_Z:    cfg_in.origin_z = csr_data;
            fmtl_pkg::REG_INV_STEP_X:  cfg_in.inv_step_x = csr_data;
            fmtl_pkg::REG_INV_STEP_Y:  cfg_in.inv_step_y = csr_data;
            fmtl_pkg::REG_INV_STEP_Z:  cfg_in.inv_step_z = csr_data;
            fmtl_pkg::REG_FIELD_SCALE: cfg_in.field_scale = csr_data;
            fmtl_pkg::REG_QUADRANT:    cfg_in.quadrant_symmetric = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{origin_x: 32'sd0, origin_y: 32'sd0, origin_z: 32'sd0,
                     inv_step_x: 32'd65536, inv_step_y: 32'd65536,
                     inv_step_z: 32'd65536, field_scale: 32'd65536,
                     quadrant_symmetric: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fmtl_front #(.NX(NX), .NY(NY), .NZ(NZ)) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .push      (push),
      .push_job  (push_job),
      .q_full    (q_full)
   );

   fmtl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .full     (q_full),
      .empty    (q_empty)
   );

   fmtl_back #(.NY(NY), .NZ(NZ)) u_back (
      .clock       (clock),
      .reset       (reset),
      .field_scale (cfg_ff.field_scale),
      .head        (head),
      .q_empty     (q_empty),
      .pop         (pop),
      .ram_we      (ram_we),
      .ram_addr    (ram_addr),
      .ram_wdata   (ram_wdata),
      .ram_rdata   (ram_rdata),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

   fmtl_ram #(.WIDTH(fmtl_pkg::ENTRY_W), .DEPTH(fmtl_pkg::DEPTH)) u_grid (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for field_map_trilinear_lookup_top: loads grid entries,
// runs queries under several register settings and compares every result word.
// Depends on fmtl_pkg and the RTL of the block only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import fmtl_pkg::*;

   localparam int GX = 32, GY = 32, GZ = 32;
   localparam int CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   field_map_trilinear_lookup_top uut (.*);

   // shadow copy of the registers and the grid
   cfg_type cfg;
   int gbx[DEPTH], gby[DEPTH], gbz[DEPTH];
   bit loaded[DEPTH];

   req_word_type word_pending_q[$];
   rsp_word_type field_due_q[$];
   int errors = 0;
   int send_idle = 0, recv_idle = 0;
   bit hold_start = 0, hold_done = 0;
   int hold_left = 0;
   int cycles = 0;
   int items_sent = 0;
   int phase_stop = 0;

   initial forever #2 clock = ~clock;

   function automatic bit map_axis(longint p, logic signed [31:0] org, logic [31:0] inv,
                                   int n, output int cidx, output longint w);
      longint diff;
      longint unsigned prod, ip, fr;
      diff = p - longint'(org);
      cidx = 0;
      w = 0;
      if (diff < 0 || inv == 0) return 0;
      prod = longint'(diff) * longint'({32'b0, inv});
      ip = prod >> 32;
      fr = prod & 64'hFFFF_FFFF;
      if (ip > n - 1) return 0;
      if (ip == n - 1) begin
         if (fr != 0) return 0;
         cidx = n - 2;
         w = 65536;
      end else begin
         cidx = int'(ip);
         w = longint'(fr >> 16);
      end
      return 1;
   endfunction

   function automatic longint blend(longint a, longint b, longint w);
      return (a * (65536 - w) + b * w + 32768) >>> 16;
   endfunction

   function automatic int grid_addr(int ix, int iy, int iz);
      return ((ix * GY + iy) * GZ + iz) & (DEPTH - 1);
   endfunction

   function automatic longint grid_comp(int a, int c);
      return (c == 0) ? gbx[a] : (c == 1) ? gby[a] : gbz[a];
   endfunction

   // folds the position by the symmetry setting and locates all three axes
   function automatic bit place_point(req_word_type q, output int ci[3], output longint w[3],
                                      output bit fx, output bit fz);
      longint x, y, z;
      bit ok;
      x = q.pos_x;
      y = q.pos_y;
      z = q.pos_z;
      fx = 0;
      fz = 0;
      if (cfg.quadrant_symmetric) begin
         if (x < 0) begin
            x = -x;
            fx = ~fx;
         end
         if (y < 0) begin
            y = -y;
            fx = ~fx;
            fz = 1;
         end
      end
      ok = map_axis(x, cfg.origin_x, cfg.inv_step_x, GX, ci[0], w[0]);
      ok = ok && map_axis(y, cfg.origin_y, cfg.inv_step_y, GY, ci[1], w[1]);
      ok = ok && map_axis(z, cfg.origin_z, cfg.inv_step_z, GZ, ci[2], w[2]);
      return ok;
   endfunction

   function automatic rsp_word_type lookup_field(req_word_type q);
      rsp_word_type r;
      int ci[3];
      longint w[3];
      bit fx, fz;
      longint f00, f10, f01, f11, f0, f1, v;
      logic signed [COMP_W-1:0] sv;
      r = '0;
      if (!place_point(q, ci, w, fx, fz)) return r;
      for (int c = 0; c < 3; c++) begin
         f00 = blend(grid_comp(grid_addr(ci[0], ci[1], ci[2]), c),
                     grid_comp(grid_addr(ci[0] + 1, ci[1], ci[2]), c), w[0]);
         f10 = blend(grid_comp(grid_addr(ci[0], ci[1] + 1, ci[2]), c),
                     grid_comp(grid_addr(ci[0] + 1, ci[1] + 1, ci[2]), c), w[0]);
         f01 = blend(grid_comp(grid_addr(ci[0], ci[1], ci[2] + 1), c),
                     grid_comp(grid_addr(ci[0] + 1, ci[1], ci[2] + 1), c), w[0]);
         f11 = blend(grid_comp(grid_addr(ci[0], ci[1] + 1, ci[2] + 1), c),
                     grid_comp(grid_addr(ci[0] + 1, ci[1] + 1, ci[2] + 1), c), w[0]);
         f0 = blend(f00, f10, w[1]);
         f1 = blend(f01, f11, w[1]);
         v = blend(f0, f1, w[2]);
         v = (v * longint'({32'b0, cfg.field_scale}) + 32768) >>> 16;
         if ((c == 0 && fx) || (c == 2 && fz)) v = -v;
         if (v > 8388607) v = 8388607;
         if (v < -8388608) v = -8388608;
         sv = v[COMP_W-1:0];
         if (c == 0) r.field_x = sv;
         else if (c == 1) r.field_y = sv;
         else r.field_z = sv;
      end
      r.inside_res = 1'b1;
      return r;
   endfunction

   function automatic logic [COMP_W-1:0] pick_comp();
      case ($urandom_range(0, 9))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         default: return COMP_W'($urandom);
      endcase
   endfunction

   function automatic req_word_type random_word();
      logic [191:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return noise[$bits(req_word_type)-1:0];
   endfunction

   task automatic push_entry(int a, logic [COMP_W-1:0] bx, logic [COMP_W-1:0] by,
                             logic [COMP_W-1:0] bz);
      req_word_type q;
      q = random_word();
      q.opcode = OP_WRITE;
      q.entry_index = ADDR_W'(a);
      q.entry_bx = bx;
      q.entry_by = by;
      q.entry_bz = bz;
      gbx[a] = $signed(bx);
      gby[a] = $signed(by);
      gbz[a] = $signed(bz);
      loaded[a] = 1;
      word_pending_q = {word_pending_q, q};
      items_sent++;
   endtask

   // loads any unwritten corner of the cell first, then queues the query
   task automatic push_query(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
      req_word_type q;
      int ci[3], a;
      longint w[3];
      bit fx, fz;
      q = random_word();
      q.opcode = OP_QUERY;
      q.pos_x = px;
      q.pos_y = py;
      q.pos_z = pz;
      if (place_point(q, ci, w, fx, fz))
         for (int k = 0; k < 8; k++) begin
            a = grid_addr(ci[0] + k[0], ci[1] + k[1], ci[2] + k[2]);
            if (!loaded[a]) push_entry(a, pick_comp(), pick_comp(), pick_comp());
         end
      word_pending_q = {word_pending_q, q};
      field_due_q = {field_due_q, lookup_field(q)};
      items_sent++;
   endtask

   // position whose scaled offset lands near the given Q32.32 target
   function automatic logic [31:0] aim(logic signed [31:0] org, logic [31:0] inv,
                                       longint unsigned target);
      longint p;
      if (inv == 0) return $urandom;
      p = longint'(org) + longint'(target / inv);
      if (p > 64'sd2147483647 || p < -64'sd2147483648) return $urandom;
      if (cfg.quadrant_symmetric && p > 0 && $urandom_range(0, 1)) p = -p;
      return p[31:0];
   endfunction

   function automatic longint unsigned pick_target(int n, bit at_top);
      if (at_top) return longint'(n - 1) << 32;
      return (longint'($urandom_range(0, n - 2)) << 32) | longint'($urandom);
   endfunction

   task automatic random_item();
      int r;
      bit top;
      r = $urandom_range(0, 99);
      top = (r >= 80 && r < 88);
      if (r < 10)
         push_entry($urandom_range(0, DEPTH - 1), pick_comp(), pick_comp(), pick_comp());
      else if (r < 88)
         push_query(aim(cfg.origin_x, cfg.inv_step_x, pick_target(GX, top && $urandom_range(0, 1))),
                    aim(cfg.origin_y, cfg.inv_step_y, pick_target(GY, top && $urandom_range(0, 1))),
                    aim(cfg.origin_z, cfg.inv_step_z, pick_target(GZ, top)));
      else
         push_query($urandom, $urandom, $urandom);
   endtask

   task automatic load_regs(cfg_type c);
      logic [31:0] vals[8];
      cfg = c;
      vals = '{c.origin_x, c.origin_y, c.origin_z, c.inv_step_x, c.inv_step_y,
               c.inv_step_z, c.field_scale, {31'b0, c.quadrant_symmetric}};
      for (int i = REG_ORIGIN_X; i <= REG_QUADRANT; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_W'(i);
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (word_pending_q.size() != 0 || req_valid || field_due_q.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic cfg_type phase_cfg(int k);
      cfg_type c;
      c = '{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 1'b0};
      case (k)
         1: c = '{-(5 <<< 16), -(3 <<< 16), 32'h0000_8000, 32'h20000, 32'h20000,
                  32'h20000, 32'h8000, 1'b1};
         2: c = '{32'h7FFF_0000, 32'h8000_0000, 0, 32'h10000, 32'hFFFF_FFFF,
                  32'h8000, 32'hFFFF_FFFF, 1'b1};
         3: c = '{$urandom, $urandom, $urandom, 32'h10000, 32'h10000, 32'h0, 32'h0, 1'b0};
         4: c = '{$urandom_range(0, 32'h40000), 0, -(1 <<< 16), 32'h30000, 32'h10000,
                  32'h18000, 32'h20000, 1'b1};
         default: ;
      endcase
      return c;
   endfunction

   initial begin
      cfg = phase_cfg(0);
      send_idle = 19;
      recv_idle = 78;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      load_regs(phase_cfg(0));
      // corner extremes, grid origin, exact top edge, just past it, below origin
      push_entry(grid_addr(0, 0, 0), 24'h7FFFFF, 24'h800000, 24'h000000);
      push_entry(grid_addr(1, 1, 1), 24'h800000, 24'h7FFFFF, 24'hFFFFFF);
      push_query(0, 0, 0);
      push_query(32'h0000_8000, 32'h0000_FFFF, 32'h0000_0001);
      push_query(31 <<< 16, 31 <<< 16, 31 <<< 16);
      push_query(0, 31 <<< 16, 32'h0001_8000);
      push_query((31 <<< 16) + 1, 0, 0);
      push_query(0, 0, (31 <<< 16) + 1);
      push_query(-1, 0, 0);
      push_query(0, 32'h8000_0000, 0);
      push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_query(32'h000F_1234, 32'h0003_ABCD, 32'h001E_FFFF);
      for (int i = 0; i < 6; i++) random_item();
      drain();
      for (int k = 0; k < 6; k++) begin
         send_idle = (k < 2) ? 19 : (k < 4) ? 78 : 0;
         recv_idle = (k < 2) ? 78 : (k < 4) ? 19 : 0;
         load_regs(phase_cfg(k));
         if (k == 4) hold_start = 1;
         // budget counts every word sent, corner loads included
         phase_stop = items_sent + ((k == 3) ? 60 : 290);
         while (items_sent < phase_stop) random_item();
         drain();
      end
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (word_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
            req_valid <= 1'b1;
            req_word <= word_pending_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall, with one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_start && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left + 1;
         if (hold_left == 800) hold_done <= 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle);
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_word_type e;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("simulation failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (field_due_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, got %h", $time, rsp_word);
            errors <= errors + 1;
         end else begin
            e = field_due_q.pop_front();
            if (rsp_word.field_x !== e.field_x)
               $display("%0t: field_x expected %h got %h", $time, e.field_x, rsp_word.field_x);
            if (rsp_word.field_y !== e.field_y)
               $display("%0t: field_y expected %h got %h", $time, e.field_y, rsp_word.field_y);
            if (rsp_word.field_z !== e.field_z)
               $display("%0t: field_z expected %h got %h", $time, e.field_z, rsp_word.field_z);
            if (rsp_word.inside_res !== e.inside_res)
               $display("%0t: inside_res expected %b got %b", $time, e.inside_res,
                        rsp_word.inside_res);
            if (rsp_word !== e) errors <= errors + 1;
         end
      end
   end

endmodule
